// ----- hw/rtl/pede_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and helper functions for the palette error-diffusion dither core.
// Depends on nothing; pede_dist, pede_diff, the top level, the checker and the testbench import it.
package pede_pkg;

  localparam int CH_W     = 8;
  localparam int ERR_W    = 9;
  localparam int EWORD_W  = 3 * ERR_W;
  localparam int COLOUR_W = 3 * CH_W;
  localparam int IDX_W    = 8;
  localparam int SQ_W     = 16;
  localparam int DIST_W   = 18;
  localparam int CFG_W    = 12;

  // Function codes carried in tuser of the input stream.
  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_PIXEL = 2'd1;
  localparam logic [1:0] FUNC_FRAME = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_LINE_WIDTH    = 2'd0;
  localparam logic [1:0] CFG_PALETTE_SIZE  = 2'd1;
  localparam logic [1:0] CFG_DITHER_ENABLE = 2'd2;

  localparam logic [11:0] LINE_WIDTH_RESET   = 12'd1;
  localparam logic [8:0]  PALETTE_SIZE_RESET = 9'd256;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_CUR0,
    ST_RD_CUR1,
    ST_RD_NXTM1,
    ST_RD_NXT0,
    ST_CAPT,
    ST_SEARCH,
    ST_DRAIN,
    ST_WR_CUR1,
    ST_WR_NXT1,
    ST_WR_NXTM1,
    ST_WR_NXT0,
    ST_OUT
  } state_t;

  // Diffusion weights in sixteenths.
  typedef enum logic [1:0] {
    WT_7,
    WT_1,
    WT_3,
    WT_5
  } weight_t;

  typedef struct packed {
    logic start;
    logic valid;
    logic last;
  } dist_ctl_t;

  typedef struct packed {
    logic                done;
    logic [IDX_W-1:0]    index;
    logic [COLOUR_W-1:0] colour;
  } dist_res_t;

  // Error words hold red in the low nine bits, then green, then blue.
  function automatic logic signed [ERR_W-1:0] err_chan(input logic [EWORD_W-1:0] w,
                                                       input int unsigned c);
    return $signed(w[c*ERR_W +: ERR_W]);
  endfunction

  // Colour words hold red in the top byte, blue in the low byte.
  function automatic logic [CH_W-1:0] pal_chan(input logic [COLOUR_W-1:0] e,
                                               input int unsigned c);
    return e[(2-c)*CH_W +: CH_W];
  endfunction

endpackage

// ----- hw/rtl/pede_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Stand-alone; used for the palette store and the error rows.
module pede_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/pede_dist.sv -----
`timescale 1ns / 1ps
// Shared distance unit: squared distance of one palette entry per cycle and running minimum.
// Depends on pede_pkg; fed by the registered read data of the palette RAM.
module pede_dist
  import pede_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  dist_ctl_t           ctl,
  input  logic [IDX_W-1:0]    index,
  input  logic [COLOUR_W-1:0] pal_word,
  input  logic [COLOUR_W-1:0] centre,
  output dist_res_t           res
);

  logic                a_valid_r, a_last_r;
  logic [IDX_W-1:0]    a_index_r;
  logic                b_valid_r, b_last_r;
  logic [IDX_W-1:0]    b_index_r;
  logic [COLOUR_W-1:0] b_colour_r;
  logic [SQ_W-1:0]     b_sq_r [3];
  logic                have_r, done_r;
  logic [DIST_W-1:0]   best_d_r;
  logic [IDX_W-1:0]    best_idx_r;
  logic [COLOUR_W-1:0] best_colour_r;
  logic [SQ_W-1:0]     sq [3];
  logic [DIST_W-1:0]   sum;

  // Stage a lines up with the RAM read latency; the squares are formed from its data.
  always_comb begin
    logic signed [CH_W:0] diff;
    logic [CH_W-1:0]      mag;
    for (int unsigned c = 0; c < 3; c++) begin
      diff  = $signed({1'b0, pal_chan(centre, c)}) - $signed({1'b0, pal_chan(pal_word, c)});
      mag   = diff[CH_W] ? CH_W'(-diff) : diff[CH_W-1:0];
      sq[c] = mag * mag;
    end
  end

  assign sum = DIST_W'(b_sq_r[0]) + DIST_W'(b_sq_r[1]) + DIST_W'(b_sq_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.start) begin
      a_valid_r <= 1'b0;
      a_last_r  <= 1'b0;
      b_valid_r <= 1'b0;
      b_last_r  <= 1'b0;
      have_r    <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      a_valid_r <= ctl.valid;
      a_last_r  <= ctl.valid && ctl.last;
      b_valid_r <= a_valid_r;
      b_last_r  <= a_valid_r && a_last_r;
      done_r    <= b_valid_r && b_last_r;
      if (b_valid_r) begin
        have_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_index_r <= index;
    if (a_valid_r) begin
      b_index_r  <= a_index_r;
      b_colour_r <= pal_word;
      for (int c = 0; c < 3; c++) begin
        b_sq_r[c] <= sq[c];
      end
    end
    // Strict compare keeps the lowest index on a tie.
    if (b_valid_r && (!have_r || sum < best_d_r)) begin
      best_d_r      <= sum;
      best_idx_r    <= b_index_r;
      best_colour_r <= b_colour_r;
    end
  end

  assign res.done   = done_r;
  assign res.index  = best_idx_r;
  assign res.colour = best_colour_r;

endmodule

// ----- hw/rtl/pede_diff.sv -----
`timescale 1ns / 1ps
// Error diffusion arithmetic: weighted share of the error in sixteenths, truncated
// toward zero, added with saturation to a stored error word. Depends on pede_pkg.
module pede_diff
  import pede_pkg::*;
(
  input  logic [EWORD_W-1:0] old_word,
  input  logic [EWORD_W-1:0] err_word,
  input  weight_t            weight,
  output logic [EWORD_W-1:0] new_word
);

  localparam int P_W = ERR_W + 4;

  logic signed [3:0] k;

  always_comb begin
    unique case (weight)
      WT_7:    k = 4'sd7;
      WT_1:    k = 4'sd1;
      WT_3:    k = 4'sd3;
      WT_5:    k = 4'sd5;
      default: k = 4'sd0;
    endcase
  end

  for (genvar c = 0; c < 3; c++) begin : g_chan
    logic signed [ERR_W-1:0] e, o, q;
    logic signed [P_W-1:0]   p, pabs, qm;
    logic signed [ERR_W:0]   s;

    assign e    = $signed(err_word[c*ERR_W +: ERR_W]);
    assign o    = $signed(old_word[c*ERR_W +: ERR_W]);
    assign p    = e * k;
    assign pabs = p[P_W-1] ? -p : p;
    assign qm   = pabs >>> 4;
    assign q    = p[P_W-1] ? ERR_W'(-qm) : ERR_W'(qm);
    assign s    = {o[ERR_W-1], o} + {q[ERR_W-1], q};
    // Overflow out of nine bits saturates to the stored range.
    assign new_word[c*ERR_W +: ERR_W] =
      (s[ERR_W] != s[ERR_W-1]) ? (s[ERR_W] ? {1'b1, {(ERR_W-1){1'b0}}}
                                           : {1'b0, {(ERR_W-1){1'b1}}})
                               : s[ERR_W-1:0];
  end

endmodule

// ----- hw/rtl/palette_error_diffusion_dither_core.sv -----
`timescale 1ns / 1ps
// Top level of the palette error-diffusion dither core: sequencer, error row and palette
// memories. Depends on pede_pkg, pede_ram, pede_dist and pede_diff.
//
//  Channel   Direction  Handshake              Payload
//  in_       slave      in_tvalid/in_tready    tdata: entry_index, red, green, blue
//                                              tuser: func
//  out_      master     out_tvalid/out_tready  tdata: palette_index, red, green, blue
//                                              tlast: row_end
//  cfg_      slave      cfg_valid/cfg_ready    cfg_index, cfg_data
//
// A palette load, a start of frame or an unused code is taken and the block stays ready.
// For a pixel the distance unit walks one palette entry per cycle through the palette RAM
// read port, framed by error row reads and write-backs on the read and write ports of the
// error RAM. The result waits in an output register; a stalled result holds the block
// only when the next pixel finishes. Reset is synchronous and needs no clearing pass:
// error rows are tracked by the column position and a fill count of the current row.
// The configuration port is always ready.
module palette_error_diffusion_dither_core
  import pede_pkg::*;
#(
  parameter int MAX_LINE_WIDTH = 2048,
  parameter int PALETTE_DEPTH  = 256,
  parameter int CELL_BITS      = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  // Input stream.
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [31:0]      in_tdata,   // entry_index[7:0], red[15:8], green[23:16], blue[31:24]
  input  logic [1:0]       in_tuser,   // func[1:0]
  // Result stream.
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [31:0]      out_tdata,  // palette_index[7:0], red[15:8], green[23:16], blue[31:24]
  output logic             out_tlast,  // row_end
  // Configuration writes.
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int XW     = (MAX_LINE_WIDTH > 1) ? $clog2(MAX_LINE_WIDTH) : 1;
  localparam int CW     = $clog2(MAX_LINE_WIDTH + 1);
  localparam int LCMP_W = (CW > 12) ? CW : 12;
  localparam int PW     = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int EDEPTH = 2 ** (XW + 1);
  localparam int SHIFT  = 8 - CELL_BITS;
  localparam int HALF   = (SHIFT > 0) ? (1 << (SHIFT - 1)) : 0;
  localparam logic [CH_W-1:0] HALF_V = CH_W'(HALF);

  state_t state_r, state_nxt;

  logic [11:0]         lw_r;
  logic [8:0]          ps_r;
  logic                de_r;
  logic [XW-1:0]       col_r, col_nxt;
  logic                bank_r, bank_nxt;
  logic [CW-1:0]       fill_r, fill_nxt;
  logic [COLOUR_W-1:0] pix_r, val_r, val_calc, centre;
  logic [EWORD_W-1:0]  ecur1_r, enm1_r, en0_r, err_r, err_calc;
  logic [8:0]          ic_r;
  logic                out_valid_r, out_valid_nxt;
  logic [31:0]         out_data_r, out_data_nxt;
  logic                out_last_r, out_last_nxt;

  logic [CW-1:0]       weff, x1;
  logic [8:0]          np, np_m1;
  logic                last, cur_ok, can_load, in_xfer, pix_xfer;

  logic                e_we;
  logic [XW:0]         e_waddr, e_raddr;
  logic [EWORD_W-1:0]  e_wdata, e_rdata, diff_old;
  weight_t             diff_wt;
  logic                p_we;
  logic [PW-1:0]       p_raddr;
  logic [COLOUR_W-1:0] p_rdata;
  dist_ctl_t           dctl;
  dist_res_t           dres;

  // Effective row width and palette size: zero acts as one, and values above the
  // storage depth are held at the depth.
  always_comb begin
    if (lw_r == '0) begin
      weff = CW'(1);
    end else if (LCMP_W'(lw_r) > LCMP_W'(MAX_LINE_WIDTH)) begin
      weff = CW'(MAX_LINE_WIDTH);
    end else begin
      weff = CW'(lw_r);
    end
    if (ps_r == '0) begin
      np = 9'd1;
    end else if (ps_r > 9'(PALETTE_DEPTH)) begin
      np = 9'(PALETTE_DEPTH);
    end else begin
      np = ps_r;
    end
  end

  assign np_m1 = np - 9'd1;
  assign x1    = CW'(col_r) + CW'(1);
  // A column at or past the last one of the width ends the row, also after a shrink.
  assign last  = (x1 >= weff);
  // The error for column x of the current row is valid when the row carried in from the
  // previous one reached it, or when the pixel to the left wrote it in this row.
  assign cur_ok   = (col_r != '0) || (fill_r != '0);
  assign can_load = !out_valid_r || out_tready;
  assign in_xfer  = in_tvalid && in_tready;
  assign pix_xfer = in_xfer && (in_tuser == FUNC_PIXEL);

  // Carried error added with clamping; the result then snaps to its cell centre.
  always_comb begin
    logic signed [ERR_W-1:0] ev;
    logic [ERR_W:0]          vsum;
    logic [CH_W:0]           e;
    for (int unsigned c = 0; c < 3; c++) begin
      ev   = (de_r && cur_ok) ? err_chan(e_rdata, c) : '0;
      vsum = {2'b00, pal_chan(pix_r, c)} + {ev[ERR_W-1], ev};
      if (vsum[ERR_W]) begin
        val_calc[(2-c)*CH_W +: CH_W] = '0;
      end else if (vsum[CH_W]) begin
        val_calc[(2-c)*CH_W +: CH_W] = '1;
      end else begin
        val_calc[(2-c)*CH_W +: CH_W] = vsum[CH_W-1:0];
      end
      centre[(2-c)*CH_W +: CH_W] = ((pal_chan(val_r, c) >> SHIFT) << SHIFT) | HALF_V;
      e = {1'b0, pal_chan(val_r, c)} - {1'b0, pal_chan(dres.colour, c)};
      err_calc[c*ERR_W +: ERR_W] = de_r ? e : '0;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (pix_xfer) state_nxt = ST_RD_CUR0;
      ST_RD_CUR0:  state_nxt = ST_RD_CUR1;
      ST_RD_CUR1:  state_nxt = ST_RD_NXTM1;
      ST_RD_NXTM1: state_nxt = ST_RD_NXT0;
      ST_RD_NXT0:  state_nxt = ST_CAPT;
      ST_CAPT:     state_nxt = ST_SEARCH;
      ST_SEARCH:   if (ic_r == np_m1) state_nxt = ST_DRAIN;
      ST_DRAIN:    if (dres.done) state_nxt = ST_WR_CUR1;
      ST_WR_CUR1:  state_nxt = ST_WR_NXT1;
      ST_WR_NXT1:  state_nxt = ST_WR_NXTM1;
      ST_WR_NXTM1: state_nxt = ST_WR_NXT0;
      ST_WR_NXT0:  state_nxt = ST_OUT;
      ST_OUT:      if (can_load) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: memory ports, distance unit control, diffusion unit select.
  // Writes into the next row do not depend on dither (zero error when dither is off), so every
  // entry up to the column reached holds a defined value.
  always_comb begin
    in_tready  = 1'b0;
    e_we       = 1'b0;
    e_waddr    = {~bank_r, col_r};
    e_raddr    = {bank_r, col_r};
    diff_old   = en0_r;
    diff_wt    = WT_5;
    p_raddr    = ic_r[PW-1:0];
    dctl.start = 1'b0;
    dctl.valid = 1'b0;
    dctl.last  = 1'b0;
    unique case (state_r)
      ST_IDLE:     in_tready = 1'b1;
      ST_RD_CUR0:  e_raddr = {bank_r, col_r};
      ST_RD_CUR1:  e_raddr = {bank_r, x1[XW-1:0]};
      ST_RD_NXTM1: e_raddr = {~bank_r, col_r - XW'(1)};
      ST_RD_NXT0:  e_raddr = {~bank_r, col_r};
      ST_CAPT:     dctl.start = 1'b1;
      ST_SEARCH: begin
        dctl.valid = 1'b1;
        dctl.last  = (ic_r == np_m1);
      end
      ST_DRAIN: ;
      ST_WR_CUR1: begin
        e_we     = !last;
        e_waddr  = {bank_r, x1[XW-1:0]};
        diff_old = ecur1_r;
        diff_wt  = WT_7;
      end
      ST_WR_NXT1: begin
        e_we     = !last;
        e_waddr  = {~bank_r, x1[XW-1:0]};
        diff_old = '0;
        diff_wt  = WT_1;
      end
      ST_WR_NXTM1: begin
        e_we     = (col_r != '0);
        e_waddr  = {~bank_r, col_r - XW'(1)};
        diff_old = enm1_r;
        diff_wt  = WT_3;
      end
      ST_WR_NXT0: begin
        e_we     = 1'b1;
        e_waddr  = {~bank_r, col_r};
        diff_old = en0_r;
        diff_wt  = WT_5;
      end
      ST_OUT: ;
      default: ;
    endcase
  end

  // Row bookkeeping and the output register.
  always_comb begin
    col_nxt       = col_r;
    bank_nxt      = bank_r;
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    if (in_xfer && (in_tuser == FUNC_FRAME)) begin
      col_nxt  = '0;
      fill_nxt = '0;
    end
    if ((state_r == ST_OUT) && can_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {pal_chan(dres.colour, 2), pal_chan(dres.colour, 1),
                       pal_chan(dres.colour, 0), dres.index};
      out_last_nxt  = last;
      if (last) begin
        // The next row becomes current; its entries up to this column are defined.
        col_nxt  = '0;
        bank_nxt = ~bank_r;
        fill_nxt = x1;
      end else begin
        col_nxt = x1[XW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lw_r        <= LINE_WIDTH_RESET;
      ps_r        <= PALETTE_SIZE_RESET;
      de_r        <= 1'b1;
      col_r       <= '0;
      bank_r      <= 1'b0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      bank_r      <= bank_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        priority case (cfg_index)
          CFG_LINE_WIDTH:    lw_r <= cfg_data[11:0];
          CFG_PALETTE_SIZE:  ps_r <= cfg_data[8:0];
          CFG_DITHER_ENABLE: de_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // Datapath holding registers.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    if (pix_xfer) begin
      pix_r <= {in_tdata[15:8], in_tdata[23:16], in_tdata[31:24]};
    end
    unique case (state_r)
      ST_RD_CUR1:  val_r   <= val_calc;
      ST_RD_NXTM1: ecur1_r <= (x1 < fill_r) ? e_rdata : '0;
      ST_RD_NXT0:  enm1_r  <= e_rdata;
      ST_CAPT: begin
        en0_r <= (col_r != '0) ? e_rdata : '0;
        ic_r  <= '0;
      end
      ST_SEARCH:   ic_r <= ic_r + 9'd1;
      ST_DRAIN:    if (dres.done) err_r <= err_calc;
      default: ;
    endcase
  end

  assign p_we = in_xfer && (in_tuser == FUNC_LOAD) &&
                ({1'b0, in_tdata[7:0]} < 9'(PALETTE_DEPTH));

  pede_ram #(
    .WIDTH(COLOUR_W),
    .DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk  (clk),
    .we   (p_we),
    .waddr(in_tdata[PW-1:0]),
    .wdata({in_tdata[15:8], in_tdata[23:16], in_tdata[31:24]}),
    .raddr(p_raddr),
    .rdata(p_rdata)
  );

  pede_ram #(
    .WIDTH(EWORD_W),
    .DEPTH(EDEPTH)
  ) u_err_rows (
    .clk  (clk),
    .we   (e_we),
    .waddr(e_waddr),
    .wdata(e_wdata),
    .raddr(e_raddr),
    .rdata(e_rdata)
  );

  pede_dist u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (dctl),
    .index   (IDX_W'(ic_r)),
    .pal_word(p_rdata),
    .centre  (centre),
    .res     (dres)
  );

  pede_diff u_diff (
    .old_word(diff_old),
    .err_word(err_r),
    .weight  (diff_wt),
    .new_word(e_wdata)
  );

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- hw/rtl/pede_chk.sv -----
`timescale 1ns / 1ps
// Port-level checker for the dither core and the bind that attaches it to the top level.
// Depends on pede_pkg and palette_error_diffusion_dither_core.
module pede_chk
  import pede_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast
);

  // A pixel starts a multi-cycle search, so the input side closes right after it.
  a_pixel_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == FUNC_PIXEL) |=> !in_tready)
    else $error("input still ready after a pixel transfer");

  // After a load, a frame start or an unused code the input side stays ready.
  a_short_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser != FUNC_PIXEL) |=> in_tready)
    else $error("input not ready after a non-pixel transfer");

  // A new result only appears when a pixel was in progress.
  a_result_from_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared while the block was idle");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("stalled result changed or dropped");

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind palette_error_diffusion_dither_core pede_chk u_pede_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tuser  (in_tuser),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tlast (out_tlast)
);

// ----- tb/sv/palette_error_diffusion_dither_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for palette_error_diffusion_dither_core: a behavioral copy of the
// palette search and Floyd-Steinberg diffusion predicts every mapped pixel on the out_ stream.
// Depends on pede_pkg and the core RTL; needs no files or arguments.
module palette_error_diffusion_dither_core_tb;
  import pede_pkg::*;

  localparam int MAX_W         = 2048;
  localparam int PAL_DEPTH     = 256;
  localparam int CELL_BITS     = 5;
  localparam int ITEM_GOAL     = 1350;
  localparam int SETTLE_CYCLES = 40;
  localparam int TAIL_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int MAX_PRINTED   = 40;

  // The fourth function code is not used by the block and must be dropped silently.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [7:0] index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       row_end;
  } mapped_pixel_t;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [31:0]      in_tdata   = '0;   // entry_index[7:0], red[15:8], green[23:16], blue[31:24]
  logic [1:0]       in_tuser   = FUNC_LOAD;  // func[1:0]
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [31:0]      out_tdata;         // palette_index[7:0], red[15:8], green[23:16], blue[31:24]
  logic             out_tlast;         // row_end
  logic             cfg_valid  = 1'b0;
  logic             cfg_ready;
  logic [1:0]       cfg_index  = CFG_LINE_WIDTH;
  logic [CFG_W-1:0] cfg_data   = '0;

  palette_error_diffusion_dither_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Shadow of the block state: palette, the two error rows and the column position.
  logic [23:0]   pal_rgb [PAL_DEPTH];
  int            err_this_row [MAX_W][3];
  int            err_next_row [MAX_W][3];
  int            column;
  logic [11:0]   reg_width;
  logic [8:0]    reg_psize;
  logic          reg_dither;
  mapped_pixel_t pending_pixels [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int stall_left     = 0;
  int items_sent     = 0;
  int pixels_seen    = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------------------

  function automatic void clear_error_rows();
    foreach (err_this_row[k, c]) begin
      err_this_row[k][c] = 0;
      err_next_row[k][c] = 0;
    end
  endfunction

  function automatic void reset_dither_state();
    foreach (pal_rgb[k]) pal_rgb[k] = '0;
    clear_error_rows();
    column     = 0;
    reg_width  = LINE_WIDTH_RESET;
    reg_psize  = PALETTE_SIZE_RESET;
    reg_dither = 1'b1;
  endfunction

  // Stored error sums are kept in nine signed bits.
  function automatic int saturate_error(input int v);
    if (v < -256) return -256;
    if (v > 255) return 255;
    return v;
  endfunction

  function automatic int clamp_channel(input int v);
    if (v < 0) return 0;
    if (v > 255) return 255;
    return v;
  endfunction

  // Centre of the quantization cell that holds v.
  function automatic int cell_centre(input int v);
    int shift;
    shift = 8 - CELL_BITS;
    return ((v >> shift) << shift) + ((shift > 0) ? (1 << (shift - 1)) : 0);
  endfunction

  function automatic int palette_channel(input int entry, input int c);
    return int'(pal_rgb[entry][(2 - c) * 8 +: 8]);
  endfunction

  function automatic void apply_register(input logic [1:0] idx, input logic [CFG_W-1:0] data);
    case (idx)
      CFG_LINE_WIDTH:    reg_width  = data[11:0];
      CFG_PALETTE_SIZE:  reg_psize  = data[8:0];
      CFG_DITHER_ENABLE: reg_dither = data[0];
      default: ;
    endcase
  endfunction

  // Applies one accepted input transfer to the shadow state. A pixel queues the palette
  // entry it should map to, and under dither pushes its error onto its neighbours.
  function automatic void map_and_diffuse(input logic [1:0] func, input logic [7:0] entry,
                                          input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
    int            chan_in [3];
    int            val [3];
    int            centre [3];
    int            err [3];
    int            w, np, x, d, diff, best_d, pick;
    logic          last;
    mapped_pixel_t px;
    chan_in[0] = r;
    chan_in[1] = g;
    chan_in[2] = b;
    case (func)
      FUNC_LOAD: pal_rgb[entry] = {r, g, b};
      FUNC_FRAME: begin
        clear_error_rows();
        column = 0;
      end
      FUNC_PIXEL: begin
        // Out-of-range register values act as the nearest legal value.
        w  = (reg_width == 0) ? 1 : ((reg_width > MAX_W) ? MAX_W : int'(reg_width));
        np = (reg_psize == 0) ? 1 : ((reg_psize > PAL_DEPTH) ? PAL_DEPTH : int'(reg_psize));
        x  = column % MAX_W;
        // A width shrunk below the current column ends the row at once.
        last = (x + 1 >= w);
        for (int c = 0; c < 3; c++) begin
          val[c]    = reg_dither ? clamp_channel(chan_in[c] + err_this_row[x][c]) : chan_in[c];
          centre[c] = cell_centre(val[c]);
        end
        // Strict less-than keeps the lowest index on equal distances.
        pick   = 0;
        best_d = 0;
        for (int i = 0; i < np; i++) begin
          d = 0;
          for (int c = 0; c < 3; c++) begin
            diff = centre[c] - palette_channel(i, c);
            d += diff * diff;
          end
          if (i == 0 || d < best_d) begin
            best_d = d;
            pick   = i;
          end
        end
        if (reg_dither) begin
          for (int c = 0; c < 3; c++) begin
            err[c] = val[c] - palette_channel(pick, c);
            if (!last) begin
              err_this_row[x + 1][c] = saturate_error(err_this_row[x + 1][c] + err[c] * 7 / 16);
              err_next_row[x + 1][c] = saturate_error(err_next_row[x + 1][c] + err[c] / 16);
            end
            if (x > 0)
              err_next_row[x - 1][c] = saturate_error(err_next_row[x - 1][c] + err[c] * 3 / 16);
            err_next_row[x][c] = saturate_error(err_next_row[x][c] + err[c] * 5 / 16);
          end
        end
        px.index   = pick[7:0];
        px.red     = pal_rgb[pick][23:16];
        px.green   = pal_rgb[pick][15:8];
        px.blue    = pal_rgb[pick][7:0];
        px.row_end = last;
        pending_pixels.push_back(px);
        // Row advance happens at every row end, dither or not.
        if (last) begin
          foreach (err_this_row[k, c]) begin
            err_this_row[k][c] = err_next_row[k][c];
            err_next_row[k][c] = 0;
          end
          column = 0;
        end else begin
          column = x + 1;
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED)
      $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("pixel %0d %s: got %0d, want %0d",
                                pixels_seen, name, got, want));
  endtask

  // One process watches all three channels, so a result can never be compared before the
  // transfer that predicts it has been applied.
  always @(posedge clk) begin : watch_streams
    mapped_pixel_t got, want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready)
        apply_register(cfg_index, cfg_data);
      if (in_tvalid && in_tready)
        map_and_diffuse(in_tuser, in_tdata[7:0], in_tdata[15:8], in_tdata[23:16],
                        in_tdata[31:24]);
      if (out_tvalid && out_tready) begin
        got.index   = out_tdata[7:0];
        got.red     = out_tdata[15:8];
        got.green   = out_tdata[23:16];
        got.blue    = out_tdata[31:24];
        got.row_end = out_tlast;
        if (pending_pixels.size() == 0) begin
          report_mismatch($sformatf("pixel %0d arrived with nothing pending (index %0d)",
                                    pixels_seen, got.index));
        end else begin
          want = pending_pixels.pop_front();
          check_field("palette_index", got.index, want.index);
          check_field("red", got.red, want.red);
          check_field("green", got.green, want.green);
          check_field("blue", got.blue, want.blue);
          check_field("row_end", got.row_end, want.row_end);
        end
        pixels_seen++;
      end
    end
  end

  // Receiver: random stalls, or a counted hold-off when a test asks for one.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: a hang or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------------------

  function automatic logic [7:0] random_channel();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  // Offers one item and returns at the edge that takes it. tvalid is left high, so the
  // next call can keep the bus busy without a gap; a gap lowers it first.
  task automatic send_item(input logic [1:0] func, input logic [7:0] entry,
                           input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {b, g, r, entry};
    do @(posedge clk); while (!in_tready);
    if (func != FUNC_UNUSED) items_sent++;
  endtask

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    send_item(FUNC_PIXEL, 8'($urandom), r, g, b);
  endtask

  task automatic send_random_pixel();
    send_pixel(random_channel(), random_channel(), random_channel());
  endtask

  // Stops offering, waits for every pending pixel, then lets a trailing load or frame
  // start finish before anything is reconfigured.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Only called once the block is drained.
  task automatic set_config(input logic [11:0] width, input logic [8:0] psize,
                            input logic dither);
    write_reg(CFG_LINE_WIDTH, width);
    write_reg(CFG_PALETTE_SIZE, CFG_W'(psize));
    write_reg(CFG_DITHER_ENABLE, CFG_W'(dither));
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  // Plain mapping without diffusion: channel extremes, a tie between equal entries, the
  // top entry index and the unused function code.
  task automatic test_direct_mapping();
    wait_drained();
    send_item(FUNC_LOAD, 8'd0, 8'h00, 8'h00, 8'h00);
    send_item(FUNC_LOAD, 8'd1, 8'hff, 8'hff, 8'hff);
    send_item(FUNC_LOAD, 8'd2, 8'h80, 8'h80, 8'h80);
    // Same colour as entry 2, so grey pixels must still pick entry 2.
    send_item(FUNC_LOAD, 8'd3, 8'h80, 8'h80, 8'h80);
    send_item(FUNC_LOAD, 8'd255, 8'h12, 8'h34, 8'h56);
    wait_drained();
    set_config(12'd4, 9'd4, 1'b0);
    send_item(FUNC_FRAME, 8'h00, 8'h00, 8'h00, 8'h00);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_item(FUNC_UNUSED, 8'hff, 8'hff, 8'hff, 8'hff);
    send_pixel(8'h80, 8'h80, 8'h80);
    send_pixel(8'h7f, 8'h40, 8'hc0);
  endtask

  // Error diffusion over two short rows, so both rows and the row advance are exercised.
  task automatic test_diffusion_rows();
    wait_drained();
    set_config(12'd3, 9'd4, 1'b1);
    send_item(FUNC_FRAME, 8'h00, 8'h00, 8'h00, 8'h00);
    send_pixel(8'd100, 8'd200, 8'd30);
    send_pixel(8'd250, 8'd5, 8'd128);
    send_pixel(8'd60, 8'd60, 8'd60);
    send_pixel(8'd200, 8'd10, 8'd90);
    send_pixel(8'd3, 8'd250, 8'd170);
    send_pixel(8'd128, 8'd128, 8'd128);
  endtask

  // Narrowing the line while the column sits past the new end must close the row.
  task automatic test_width_shrink();
    wait_drained();
    set_config(12'd5, 9'd4, 1'b1);
    send_pixel(8'd90, 8'd170, 8'd20);
    send_pixel(8'd180, 8'd40, 8'd220);
    wait_drained();
    set_config(12'd2, 9'd4, 1'b1);
    send_pixel(8'd10, 8'd120, 8'd240);
    send_pixel(8'd240, 8'd120, 8'd10);
  endtask

  // Zero width and zero palette size behave as one.
  task automatic test_register_floor();
    wait_drained();
    set_config(12'd0, 9'd0, 1'b1);
    send_pixel(8'd77, 8'd155, 8'd233);
  endtask

  // A one-entry palette far from the pixels drives the carried errors toward their limits,
  // first positive and then negative.
  task automatic test_extreme_error();
    wait_drained();
    set_config(12'd2, 9'd1, 1'b1);
    send_item(FUNC_FRAME, 8'h00, 8'h00, 8'h00, 8'h00);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_item(FUNC_LOAD, 8'd0, 8'hff, 8'hff, 8'hff);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'h00, 8'h00, 8'h00);
  endtask

  // Fills the whole palette, then a few pixels search all of it at the widest settings.
  task automatic test_full_palette();
    wait_drained();
    for (int k = 0; k < PAL_DEPTH; k++)
      send_item(FUNC_LOAD, 8'(k), random_channel(), random_channel(), random_channel());
    wait_drained();
    set_config(12'd2048, 9'd256, 1'b1);
    send_item(FUNC_FRAME, 8'h00, 8'h00, 8'h00, 8'h00);
    repeat (4) send_random_pixel();
    wait_drained();
    set_config(12'hfff, 9'h1ff, 1'b0);
    repeat (3) send_random_pixel();
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering, so the
  // output register fills and the block stops taking input.
  task automatic test_backpressure();
    int saved_idle;
    wait_drained();
    saved_idle    = send_idle_pct;
    send_idle_pct = 0;
    set_config(12'd6, 9'd6, 1'b1);
    send_item(FUNC_FRAME, 8'h00, 8'h00, 8'h00, 8'h00);
    stall_left = 1200;
    repeat (40) send_random_pixel();
    wait_drained();
    send_idle_pct = saved_idle;
  endtask

  // One frame under a random setting: a palette refresh, usually a frame start, then
  // pixels with some noise mixed in (unused codes, stray loads, frame starts mid-row).
  task automatic random_scene();
    int   pick, width, psize, eff_psize, eff_width, pixel_total, n_loads;
    logic dither;
    wait_drained();
    pick = $urandom_range(99);
    if (pick < 5) psize = ($urandom_range(1) != 0) ? 256 : 511;
    else if (pick < 9) psize = 0;
    else if (pick < 14) psize = $urandom_range(25, 255);
    else psize = $urandom_range(1, 24);
    eff_psize = (psize == 0) ? 1 : ((psize > PAL_DEPTH) ? PAL_DEPTH : psize);
    pick = $urandom_range(99);
    if (pick < 4) width = 0;
    else if (pick < 8) width = ($urandom_range(1) != 0) ? MAX_W : $urandom_range(2049, 4095);
    else if (pick < 14) width = $urandom_range(13, MAX_W);
    else width = $urandom_range(1, 12);
    eff_width = (width == 0) ? 1 : ((width > MAX_W) ? MAX_W : width);
    dither = ($urandom_range(3) != 0);
    set_config(width[11:0], psize[8:0], dither);
    n_loads = $urandom_range(0, (eff_psize < 8) ? eff_psize : 8);
    repeat (n_loads)
      send_item(FUNC_LOAD, 8'($urandom_range(eff_psize - 1)), random_channel(),
                random_channel(), random_channel());
    if ($urandom_range(99) < 85)
      send_item(FUNC_FRAME, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    // Wide palettes make each pixel slow, so those scenes stay short.
    if (eff_psize > 24) begin
      pixel_total = $urandom_range(2, 6);
    end else begin
      pixel_total = eff_width * $urandom_range(1, 4);
      if (pixel_total > 64) pixel_total = $urandom_range(16, 64);
    end
    repeat (pixel_total) begin
      pick = $urandom_range(99);
      if (pick < 3)
        send_item(FUNC_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      else if (pick < 6)
        send_item(FUNC_LOAD, 8'($urandom), random_channel(), random_channel(),
                  random_channel());
      else if (pick < 8)
        send_item(FUNC_FRAME, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      send_random_pixel();
    end
  endtask

  // Rotates through the idling modes, one per scene, until enough items have gone in.
  task automatic test_random_frames();
    int scene;
    scene = 0;
    while (items_sent < ITEM_GOAL) begin
      case (scene % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 88;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 88;
        end
        default: begin
          send_idle_pct  = 16;
          recv_stall_pct = 16;
        end
      endcase
      random_scene();
      scene++;
    end
  endtask

  initial begin
    reset_dither_state();
    send_idle_pct  = 16;
    recv_stall_pct = 16;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_direct_mapping();
    test_diffusion_rows();
    test_width_shrink();
    test_register_floor();
    test_extreme_error();
    test_full_palette();
    test_backpressure();
    test_random_frames();
    wait_drained();
    // Anything that still shows up now has no prediction and is counted as a mismatch.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
